// ===== sv/mlne_pkg.sv =====
// Shared constants for the multilinear neuron evaluator.
package mlne_pkg;

    localparam int DATA_W        = 16;
    localparam int TERM_W        = DATA_W + 1;
    localparam int FRAC_W        = 15;
    localparam int INDEX_W       = 4;
    localparam int FIELD_INPUTS  = 4;

    localparam int DEF_INPUT_COUNT = 4;
    localparam int DEF_NUM_TERMS   = 16;

    localparam logic signed [DATA_W-1:0] Q_ONE_MAX   = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] Q_MINUS_ONE = 16'sh8000;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

endpackage

// ===== sv/mlne_coef_cell.sv =====
// One coefficient cell of the rotating coefficient ring.
module mlne_coef_cell
    import mlne_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic [INDEX_W-1:0]       i_wr_idx,
    input  logic signed [DATA_W-1:0] i_wr_value,
    input  logic                     i_shift,
    input  logic signed [DATA_W-1:0] i_shift_in,
    output logic signed [DATA_W-1:0] o_coef
);

    logic signed [DATA_W-1:0] r_coef;
    logic                     w_hit;

    assign w_hit  = ({{(32-INDEX_W){1'b0}}, i_wr_idx} == 32'(IDX));
    assign o_coef = r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_shift) begin
            r_coef <= i_shift_in;
        end else if (i_load && w_hit) begin
            r_coef <= i_wr_value;
        end
    end

endmodule

// ===== sv/mlne_term_stage.sv =====
// One multiply stage of the term pipeline: scales the term by one input when selected.
module mlne_term_stage
    import mlne_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int TW    = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [TW-1:0]            i_idx,
    input  logic signed [TERM_W-1:0] i_term,
    input  logic signed [DATA_W-1:0] i_x,
    output logic                     o_valid,
    output logic [TW-1:0]            o_idx,
    output logic signed [TERM_W-1:0] o_term
);

    localparam int PROD_W = TERM_W + DATA_W;

    logic                     w_sel;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [TERM_W-1:0] w_scaled;
    logic                     r_valid;
    logic [TW-1:0]            r_idx;
    logic signed [TERM_W-1:0] r_term;

    generate
        if (STAGE < TW) begin : g_sel
            assign w_sel = i_idx[STAGE];
        end else begin : g_nosel
            assign w_sel = 1'b0;
        end
    endgenerate

    // The product never exceeds 2^30 in magnitude, so the floor shift fits the term width.
    assign w_prod   = PROD_W'(i_term) * PROD_W'(i_x);
    assign w_scaled = w_prod[FRAC_W+TERM_W-1 -: TERM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= i_idx;
        r_term <= w_sel ? w_scaled : i_term;
    end

    assign o_valid = r_valid;
    assign o_idx   = r_idx;
    assign o_term  = r_term;

endmodule

// ===== sv/multilinear_neuron_eval_core.sv =====
// Multilinear neuron evaluator: coefficient ring, term pipeline and accumulator.
// A load transaction writes its coefficient and gives no result.
// An evaluate transaction feeds the ring through the term pipeline into the accumulator;
// the ring presents one coefficient per cycle during the feed.
// One evaluation is in flight at a time; no transaction is taken until the result is
// registered, and the result waits in the finish state while the output register is full.
// Synchronous active-low reset clears all coefficients, the last output and all control state.
module multilinear_neuron_eval_core
    import mlne_pkg::*;
#(
    parameter int INPUT_COUNT = DEF_INPUT_COUNT,
    parameter int NUM_TERMS   = DEF_NUM_TERMS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_mode,
    input  logic [INDEX_W-1:0]       i_coef_index,
    input  logic signed [DATA_W-1:0] i_coef_value,
    input  logic signed [DATA_W-1:0] i_in_a,
    input  logic signed [DATA_W-1:0] i_in_b,
    input  logic signed [DATA_W-1:0] i_in_c,
    input  logic signed [DATA_W-1:0] i_in_d,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic                     o_changed
);

    localparam int TW = $clog2(NUM_TERMS);
    localparam int CW = $clog2(NUM_TERMS + 1);
    localparam int AW = TERM_W + TW + 1;

    localparam logic signed [AW-1:0] ACC_MAX = AW'(Q_ONE_MAX);
    localparam logic signed [AW-1:0] ACC_MIN = AW'(Q_MINUS_ONE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                   r_state;
    logic [TW-1:0]            r_feed_idx;
    logic [CW-1:0]            r_acc_cnt;
    logic signed [AW-1:0]     r_acc;
    logic signed [DATA_W-1:0] r_last;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_changed;

    logic signed [DATA_W-1:0] w_field_x [FIELD_INPUTS];
    logic signed [DATA_W-1:0] w_x       [INPUT_COUNT];
    logic signed [DATA_W-1:0] w_coef    [NUM_TERMS];
    logic                     w_pv      [INPUT_COUNT+1];
    logic [TW-1:0]            w_pidx    [INPUT_COUNT+1];
    logic signed [TERM_W-1:0] w_pterm   [INPUT_COUNT+1];

    logic                     w_accept;
    logic                     w_load;
    logic                     w_shift;
    logic                     w_out_free;
    logic signed [DATA_W-1:0] w_result;

    assign w_field_x[0] = i_in_a;
    assign w_field_x[1] = i_in_b;
    assign w_field_x[2] = i_in_c;
    assign w_field_x[3] = i_in_d;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = w_accept && (i_mode == MODE_LOAD);
    assign w_shift    = (r_state == S_FEED);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Inputs are captured on acceptance; inputs beyond the four fields read as zero.
    generate
        for (genvar j = 0; j < INPUT_COUNT; j++) begin : g_x
            if (j < FIELD_INPUTS) begin : g_reg
                logic signed [DATA_W-1:0] r_x;
                always_ff @(posedge i_clk) begin
                    if (w_accept && (i_mode == MODE_EVAL)) begin
                        r_x <= w_field_x[j];
                    end
                end
                assign w_x[j] = r_x;
            end else begin : g_zero
                assign w_x[j] = '0;
            end
        end
    endgenerate

    // The ring rotates towards cell 0 once per feed cycle and is back in place when the feed ends.
    generate
        for (genvar k = 0; k < NUM_TERMS; k++) begin : g_cell
            mlne_coef_cell #(
                .IDX(k)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_load     (w_load),
                .i_wr_idx   (i_coef_index),
                .i_wr_value (i_coef_value),
                .i_shift    (w_shift),
                .i_shift_in (w_coef[(k + 1) % NUM_TERMS]),
                .o_coef     (w_coef[k])
            );
        end
    endgenerate

    assign w_pv[0]    = w_shift;
    assign w_pidx[0]  = r_feed_idx;
    assign w_pterm[0] = TERM_W'(w_coef[0]);

    generate
        for (genvar j = 0; j < INPUT_COUNT; j++) begin : g_stage
            mlne_term_stage #(
                .STAGE(j),
                .TW   (TW)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_pv[j]),
                .i_idx   (w_pidx[j]),
                .i_term  (w_pterm[j]),
                .i_x     (w_x[j]),
                .o_valid (w_pv[j+1]),
                .o_idx   (w_pidx[j+1]),
                .o_term  (w_pterm[j+1])
            );
        end
    endgenerate

    always_comb begin
        if (r_acc > ACC_MAX) begin
            w_result = Q_ONE_MAX;
        end else if (r_acc < ACC_MIN) begin
            w_result = Q_MINUS_ONE;
        end else begin
            w_result = r_acc[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_feed_idx  <= '0;
            r_acc_cnt   <= '0;
            r_acc       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_out_value <= '0;
            r_changed   <= 1'b0;
        end else begin
            // In the finish state the valid flag is set below whenever the register frees up.
            if (r_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            if (w_pv[INPUT_COUNT]) begin
                r_acc     <= r_acc + AW'(w_pterm[INPUT_COUNT]);
                r_acc_cnt <= r_acc_cnt + CW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_mode == MODE_EVAL)) begin
                        r_feed_idx <= '0;
                        r_acc_cnt  <= '0;
                        r_acc      <= '0;
                        r_state    <= S_FEED;
                    end
                end
                S_FEED: begin
                    r_feed_idx <= r_feed_idx + TW'(1);
                    if (r_feed_idx == TW'(NUM_TERMS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_acc_cnt == CW'(NUM_TERMS)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= w_result;
                        r_changed   <= (w_result != r_last);
                        r_last      <= w_result;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_changed   = r_changed;

    a_acc_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_cnt <= CW'(NUM_TERMS))
        else $error("more terms accumulated than the table holds");

    a_pipe_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_pv[INPUT_COUNT])
        else $error("term pipeline still busy while idle");

    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && w_out_free) |=> (r_out_valid && r_last == r_out_value))
        else $error("finished evaluation did not register its result");

    a_feed_ring_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FEED) |-> !o_in_ready)
        else $error("transaction taken while the ring rotates");

endmodule

// ===== bench/multilinear_neuron_eval_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the multilinear neuron evaluator core.
module multilinear_neuron_eval_core_tb;
    import mlne_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SINK_HOLD    = 400;
    localparam int SETTLE_WAIT  = 60;
    localparam int TARGET_ITEMS = 1750;

    typedef struct {
        logic                     mode;
        logic [INDEX_W-1:0]       index;
        logic signed [DATA_W-1:0] coef;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] d;
    } t_neuron_item;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     changed;
    } t_neuron_result;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_ready;
    logic                     i_mode       = MODE_LOAD;
    logic [INDEX_W-1:0]       i_coef_index = '0;
    logic signed [DATA_W-1:0] i_coef_value = '0;
    logic signed [DATA_W-1:0] i_in_a       = '0;
    logic signed [DATA_W-1:0] i_in_b       = '0;
    logic signed [DATA_W-1:0] i_in_c       = '0;
    logic signed [DATA_W-1:0] i_in_d       = '0;
    logic                     o_out_valid;
    logic                     i_out_ready  = 1'b0;
    logic signed [DATA_W-1:0] o_out_value;
    logic                     o_changed;

    // Shadow copy of the block's state.
    logic signed [DATA_W-1:0] coef_store [DEF_NUM_TERMS];
    logic signed [DATA_W-1:0] prev_output;
    t_neuron_result           pending_results [$];

    int error_count = 0;
    int sent_items  = 0;
    int next_gap    = 0;
    int sink_hold   = 0;
    int quiet_count = 0;
    bit idle_on     = 1'b1;

    multilinear_neuron_eval_core #(
        .INPUT_COUNT (DEF_INPUT_COUNT),
        .NUM_TERMS   (DEF_NUM_TERMS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_in_a       (i_in_a),
        .i_in_b       (i_in_b),
        .i_in_c       (i_in_c),
        .i_in_d       (i_in_d),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_value  (o_out_value),
        .o_changed    (o_changed)
    );

    always #2 i_clk = ~i_clk;

    // Sum of all terms, each term being its coefficient multiplied by the selected
    // inputs with a floor shift after every multiply, then clamped to [-1, Q_ONE_MAX].
    function automatic logic signed [DATA_W-1:0] neuron_sum(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic signed [DATA_W-1:0] c,
        input logic signed [DATA_W-1:0] d
    );
        logic signed [63:0] x [FIELD_INPUTS];
        logic signed [63:0] term;
        logic signed [63:0] acc;
        x[0] = a;
        x[1] = b;
        x[2] = c;
        x[3] = d;
        acc  = 0;
        for (int t = 0; t < DEF_NUM_TERMS; t++) begin
            term = coef_store[t];
            for (int j = 0; j < DEF_INPUT_COUNT; j++) begin
                if (((t >> j) & 1) != 0) begin
                    term = (term * x[j]) >>> FRAC_W;
                end
            end
            acc += term;
        end
        if (acc > 64'sd32767) begin
            return Q_ONE_MAX;
        end else if (acc < -64'sd32768) begin
            return Q_MINUS_ONE;
        end
        return acc[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_q();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0: return Q_ONE_MAX;
                    1: return Q_MINUS_ONE;
                    2: return 16'sd0;
                    3: return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            1: return $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_neuron_item load_item(input int idx, input logic signed [DATA_W-1:0] v);
        t_neuron_item it;
        it       = '{default: '0};
        it.mode  = MODE_LOAD;
        it.index = idx[INDEX_W-1:0];
        it.coef  = v;
        it.a     = 16'($urandom);
        it.b     = 16'($urandom);
        it.c     = 16'($urandom);
        it.d     = 16'($urandom);
        return it;
    endfunction

    function automatic t_neuron_item eval_item(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic signed [DATA_W-1:0] c,
        input logic signed [DATA_W-1:0] d
    );
        t_neuron_item it;
        it.mode  = MODE_EVAL;
        it.index = INDEX_W'($urandom);
        it.coef  = 16'($urandom);
        it.a     = a;
        it.b     = b;
        it.c     = c;
        it.d     = d;
        return it;
    endfunction

    // Offers one transaction and updates the shadow state when it is taken.
    task automatic send_item(input t_neuron_item it);
        t_neuron_result r;
        repeat (next_gap) @(posedge i_clk);
        i_in_valid   <= 1'b1;
        i_mode       <= it.mode;
        i_coef_index <= it.index;
        i_coef_value <= it.coef;
        i_in_a       <= it.a;
        i_in_b       <= it.b;
        i_in_c       <= it.c;
        i_in_d       <= it.d;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sent_items++;
        if (it.mode == MODE_LOAD) begin
            coef_store[it.index] = it.coef;
        end else begin
            r.value   = neuron_sum(it.a, it.b, it.c, it.d);
            r.changed = (r.value != prev_output);
            prev_output = r.value;
            pending_results.push_back(r);
        end
        next_gap = idle_on ? $urandom_range(0, 4) : 0;
        if (next_gap != 0) begin
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic wait_for_results();
        // Valid is still high only when no gap was drawn after the last transaction.
        if (next_gap == 0) begin
            i_in_valid <= 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_extremes();
        send_item(eval_item(Q_ONE_MAX, Q_MINUS_ONE, 16'sh5555, -16'sh5556));
        send_item(load_item(0, Q_ONE_MAX));
        send_item(eval_item(16'sd0, 16'sd0, 16'sd0, 16'sd0));
        send_item(eval_item(16'sd0, 16'sd0, 16'sd0, 16'sd0));
        send_item(load_item(0, Q_MINUS_ONE));
        send_item(eval_item(16'sd0, 16'sd0, 16'sd0, 16'sd0));
        // Minus one times minus one gives a term of exactly +1.0 before the clamp.
        send_item(load_item(0, 16'sd0));
        send_item(load_item(1, Q_MINUS_ONE));
        send_item(eval_item(Q_MINUS_ONE, 16'sd0, 16'sd0, 16'sd0));
        // A tiny negative product rounds towards minus infinity.
        send_item(load_item(1, -16'sd1));
        send_item(eval_item(16'sd1, 16'sd0, 16'sd0, 16'sd0));
        send_item(load_item(1, 16'sd0));
        send_item(load_item(15, Q_ONE_MAX));
        send_item(eval_item(Q_MINUS_ONE, Q_MINUS_ONE, Q_MINUS_ONE, Q_MINUS_ONE));
        send_item(load_item(2, Q_ONE_MAX));
        send_item(load_item(4, Q_ONE_MAX));
        send_item(load_item(8, Q_ONE_MAX));
        send_item(eval_item(Q_ONE_MAX, Q_ONE_MAX, Q_ONE_MAX, Q_ONE_MAX));
        send_item(eval_item(Q_MINUS_ONE, Q_MINUS_ONE, Q_MINUS_ONE, 16'sd1));
        send_item(eval_item(16'shAAAA, 16'sh5555, -16'sd1, 16'sh7F00));
        wait_for_results();
    endtask

    // The sink stops taking results for a long stretch while evaluations keep coming.
    task automatic test_output_backpressure();
        sink_hold = SINK_HOLD;
        repeat (8) begin
            send_item(load_item($urandom_range(0, 15), pick_q()));
            send_item(eval_item(pick_q(), pick_q(), pick_q(), pick_q()));
        end
        wait_for_results();
    endtask

    task automatic test_sender_pause();
        repeat (3) begin
            send_item(load_item($urandom_range(0, 15), pick_q()));
            send_item(eval_item(pick_q(), pick_q(), pick_q(), pick_q()));
            send_item(eval_item(pick_q(), pick_q(), pick_q(), pick_q()));
            wait_for_results();
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int           stop_at;
        t_neuron_item ev;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at) begin
            if ($urandom_range(0, 24) == 0) begin
                idle_on = !idle_on;
            end
            repeat ($urandom_range(0, 3)) begin
                send_item(load_item($urandom_range(0, 15), pick_q()));
            end
            ev = eval_item(pick_q(), pick_q(), pick_q(), pick_q());
            send_item(ev);
            // Repeating an evaluation unchanged must clear the change flag.
            if ($urandom_range(0, 7) == 0) begin
                send_item(ev);
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        for (int k = 0; k < DEF_NUM_TERMS; k++) begin
            coef_store[k] = '0;
        end
        prev_output = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic(TARGET_ITEMS - sent_items);
        wait_for_results();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Result sink: a random stall before each result, or a long one on request.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 4) : 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_ready));
        end
    end

    always @(posedge i_clk) begin
        t_neuron_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: out_value %0d changed %0b",
                       o_out_value, o_changed);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_value !== want.value) begin
                    $error("out_value: expected %0d, actual %0d", want.value, o_out_value);
                    error_count++;
                end
                if (o_changed !== want.changed) begin
                    $error("changed: expected %0b, actual %0b", want.changed, o_changed);
                    error_count++;
                end
            end
        end
    end

    // Ends the run if no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

endmodule

// ===== filelist.f =====
sv/mlne_pkg.sv
sv/mlne_coef_cell.sv
sv/mlne_term_stage.sv
sv/multilinear_neuron_eval_core.sv
bench/multilinear_neuron_eval_core_tb.sv
